// ===== design/metaball_field_cell_top_defines.svh =====
// Assertion macros used by the metaball field cell top module.
// Each macro expects clk and rst to be visible in the using module.
`ifndef METABALL_FIELD_CELL_TOP_DEFINES_SVH
`define METABALL_FIELD_CELL_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MFC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfc assertion failed");

// Next-cycle implication, checked outside reset.
`define MFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mfc assertion failed");

`endif

// ===== design/mfc_pkg.sv =====
// Package for the metaball field cell: field widths, constants, state type.
// No dependencies.
package mfc_pkg;
  localparam int BLOB_COUNT_DEF   = 8;
  localparam int SCALE_FACTOR_DEF = 2;
  localparam int POS_W            = 10;
  localparam int GAIN_W           = 24;
  localparam int CELL_W           = 9;
  localparam int IDX_W            = 3;
  localparam int FIELD_W          = 8;
  localparam int FIELD_BIAS       = 16;
  localparam int FIELD_MAX        = 255;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_SQ,
    ST_DEN,
    ST_CHK,
    ST_DIV,
    ST_DONE
  } mfc_state_t;
endpackage

// ===== design/metaball_field_cell_top.sv =====
// Metaball field cell: blob table in RAM, sequential per-blob field sum.
// Depends on mfc_pkg, mfc_ram, mfc_div and metaball_field_cell_top_defines.svh.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid, in_stall | action, blob_index, blob_x, blob_y,
//          |                    | blob_strength, cell_x, cell_y
//  out     | out_valid,out_stall| field_value
//
// A load item writes one blob entry; it gives no result.
// A compute item visits every blob in turn: it reads the entry and forms the
// denominator, then uses the shared one-bit-per-cycle divider only when the
// strength is not below the denominator.
// Reset clears the per-entry valid bits at once; an unloaded blob reads as
// zero strength at zero distance, so it is skipped without a divide. The
// result sits in an output register, so the next item is taken while it
// waits; a finished sum waits for that register to free up.
`include "metaball_field_cell_top_defines.svh"
module metaball_field_cell_top #(
  parameter int BLOB_COUNT   = mfc_pkg::BLOB_COUNT_DEF,
  parameter int SCALE_FACTOR = mfc_pkg::SCALE_FACTOR_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic [mfc_pkg::IDX_W-1:0]    blob_index,
  input  logic [mfc_pkg::POS_W-1:0]    blob_x,
  input  logic [mfc_pkg::POS_W-1:0]    blob_y,
  input  logic [mfc_pkg::GAIN_W-1:0]   blob_strength,
  input  logic [mfc_pkg::CELL_W-1:0]   cell_x,
  input  logic [mfc_pkg::CELL_W-1:0]   cell_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mfc_pkg::FIELD_W-1:0]  field_value
);
  import mfc_pkg::*;

  // Address width of the blob table, widths of the distance arithmetic, the entry and the sum.
  localparam int AW    = (BLOB_COUNT > 1) ? $clog2(BLOB_COUNT) : 1;
  localparam int PW    = CELL_W + $clog2(SCALE_FACTOR + 1);
  localparam int DXW   = (PW > POS_W) ? PW : POS_W;
  localparam int SQW   = 2 * DXW;
  localparam int DENW  = SQW + 2;
  localparam int CMPW  = (DENW > GAIN_W) ? DENW : GAIN_W;
  localparam int ENTW  = 2 * POS_W + GAIN_W;
  localparam int SUMW  = GAIN_W + 1;

  mfc_state_t state, state_next;

  logic [AW-1:0]         idx;
  logic [BLOB_COUNT-1:0] loaded;
  logic [DXW-1:0]        px, py;
  logic [DXW-1:0]        dx, dy;
  logic [SQW-1:0]        dx2, dy2;
  logic [DENW-1:0]       den;
  logic [GAIN_W-1:0]     gain;
  logic [FIELD_W-1:0]    acc;

  logic                  in_acc;
  logic                  load_we;
  logic [ENTW-1:0]       rd_entry;
  logic [DXW-1:0]        col, row;
  logic                  div_start, div_done;
  logic [GAIN_W-1:0]     div_q;
  logic                  add_en;
  logic [GAIN_W-1:0]     add_val;
  logic [SUMW-1:0]       sum;
  logic                  last_blob;
  logic                  out_free;

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_we   = in_acc && (action == ACT_LOAD)
                     && ({2'b00, blob_index} < 5'(BLOB_COUNT));
  assign last_blob = (idx == AW'(BLOB_COUNT - 1));
  assign out_free  = !out_valid || !out_stall;

  // Each entry packs column, row and strength side by side.
  mfc_ram #(.WIDTH(ENTW), .DEPTH(BLOB_COUNT), .AW(AW)) u_blob_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(blob_index)),
    .wdata ({blob_x, blob_y, blob_strength}),
    .raddr (idx),
    .rdata (rd_entry)
  );

  mfc_div #(.NUMW(GAIN_W), .DENW(DENW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (gain),
    .den   (den),
    .done  (div_done),
    .quot  (div_q)
  );

  assign col = DXW'(rd_entry[ENTW-1 -: POS_W]);
  assign row = DXW'(rd_entry[GAIN_W +: POS_W]);

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    add_en     = 1'b0;
    add_val    = div_q;
    case (state)
      ST_IDLE: begin
        if (in_acc && action == ACT_COMPUTE) state_next = ST_READ;
      end
      ST_READ: state_next = ST_DIFF;
      ST_DIFF: state_next = ST_SQ;
      ST_SQ:   state_next = ST_DEN;
      ST_DEN:  state_next = ST_CHK;
      ST_CHK: begin
        // A strength below the denominator contributes zero; skip the divide.
        if (CMPW'(gain) < CMPW'(den)) begin
          state_next = last_blob ? ST_DONE : ST_READ;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          add_en     = 1'b1;
          state_next = last_blob ? ST_DONE : ST_READ;
        end
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign sum = SUMW'(acc) + SUMW'(add_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded    <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_we) loaded[AW'(blob_index)] <= 1'b1;
      if (state == ST_IDLE) begin
        idx <= '0;
      end else if ((state == ST_CHK && state_next != ST_DIV) ||
                   (state == ST_DIV && div_done)) begin
        if (!last_blob) idx <= idx + 1'b1;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers: scaled cell position, one blob term, the running sum and the result.
  always_ff @(posedge clk) begin
    if (in_acc && action == ACT_COMPUTE) begin
      px  <= DXW'(cell_x) * DXW'(SCALE_FACTOR);
      py  <= DXW'(cell_y) * DXW'(SCALE_FACTOR);
      acc <= '0;
    end
    if (state == ST_DIFF) begin
      // An entry never loaded holds no defined position; treat it as an
      // empty blob right on the cell.
      if (loaded[idx]) begin
        dx   <= (px >= col) ? (px - col) : (col - px);
        dy   <= (py >= row) ? (py - row) : (row - py);
        gain <= rd_entry[GAIN_W-1:0];
      end else begin
        dx   <= '0;
        dy   <= '0;
        gain <= '0;
      end
    end
    if (state == ST_SQ) begin
      dx2 <= SQW'(dx) * SQW'(dx);
      dy2 <= SQW'(dy) * SQW'(dy);
    end
    if (state == ST_DEN) begin
      den <= DENW'(dx2) + DENW'(dy2) + DENW'(FIELD_BIAS);
    end
    if (add_en) begin
      acc <= (sum > SUMW'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX) : sum[FIELD_W-1:0];
    end
    if (state == ST_DONE && out_free) begin
      field_value <= acc;
    end
  end

  `MFC_ASSERT_NEXT(a_compute_starts, in_acc && action == ACT_COMPUTE, state == ST_READ)
  `MFC_ASSERT_NOW(a_idx_in_range, 1'b1, idx <= AW'(BLOB_COUNT - 1))
  `MFC_ASSERT_NOW(a_result_from_done, $rose(out_valid), $past(state) == ST_DONE)
  `MFC_ASSERT_NEXT(a_load_stays_idle, in_acc && action == ACT_LOAD, state == ST_IDLE)
endmodule

// ===== design/mfc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/mfc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module mfc_div #(
  parameter int NUMW = 24,
  parameter int DENW = 22
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic            done,
  output logic [NUMW-1:0] quot
);
  localparam int CW = (NUMW > 1) ? $clog2(NUMW) : 1;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DENW-1:0] rem;
  logic [DENW-1:0] dsr;
  logic [DENW:0]   shifted;
  logic            ge;

  assign shifted = {rem, quot[NUMW-1]};
  assign ge      = (shifted >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUMW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
      dsr  <= den;
    end else if (busy) begin
      rem  <= ge ? DENW'(shifted - {1'b0, dsr}) : shifted[DENW-1:0];
      quot <= {quot[NUMW-2:0], ge};
    end
  end
endmodule
